@@ src/sle_pkg.sv @@
// ---------------------------------------------------------------------------
// Sorted list engine package
// Shared sizes, request and status codes, and the cell command type.
// ---------------------------------------------------------------------------
package sle_pkg;

    localparam int DEPTH     = 64;
    localparam int DATA_W    = 32;
    localparam int REQ_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int OUT_POS_W = 6;
    localparam int OUT_CNT_W = 7;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic                     ins;
        logic                     del;
        logic signed [DATA_W-1:0] value;
    } cell_cmd_t;

    function automatic logic [IDX_W-1:0] encode_onehot(input logic [DEPTH-1:0] onehot);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (onehot[i])
            begin
                idx = idx | IDX_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [OUT_POS_W-1:0] fit_pos(input logic [IDX_W-1:0] idx);
        logic [IDX_W+OUT_POS_W-1:0] wide;
        wide = {{OUT_POS_W{1'b0}}, idx};
        return wide[OUT_POS_W-1:0];
    endfunction

    function automatic logic [OUT_CNT_W-1:0] fit_cnt(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+OUT_CNT_W-1:0] wide;
        wide = {{OUT_CNT_W{1'b0}}, cnt};
        return wide[OUT_CNT_W-1:0];
    endfunction

endpackage

@@ src/sle_cell.sv @@
// ---------------------------------------------------------------------------
// Sorted list cell
// Holds one entry, compares it with the request value and shifts toward
// or away from its neighbors on insert and delete.
// ---------------------------------------------------------------------------
module sle_cell
(
    input  logic                                clk,
    input  sle_pkg::cell_cmd_t                  cmd,
    input  logic                                occupied,
    input  logic                                left_lt,
    input  logic signed [sle_pkg::DATA_W-1:0]   left_val,
    input  logic signed [sle_pkg::DATA_W-1:0]   right_val,
    output logic signed [sle_pkg::DATA_W-1:0]   val,
    output logic                                lt,
    output logic                                eq
);

    logic signed [sle_pkg::DATA_W-1:0] val_reg;
    logic signed [sle_pkg::DATA_W-1:0] val_next;

    assign lt  = occupied && (val_reg < cmd.value);
    assign eq  = occupied && (val_reg == cmd.value);
    assign val = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (cmd.ins && !lt)
        begin
            val_next = left_lt ? cmd.value : left_val;
        end
        else if (cmd.del && !lt)
        begin
            val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

@@ src/sle_out_stage.sv @@
// ---------------------------------------------------------------------------
// Sorted list result stage
// Encodes the position of the registered match flags and holds the result
// until the receiver takes it.
// ---------------------------------------------------------------------------
module sle_out_stage
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s1_valid,
    input  logic [sle_pkg::STATUS_W-1:0]      s1_status,
    input  logic [sle_pkg::DEPTH-1:0]         s1_onehot,
    input  logic [sle_pkg::CNT_W-1:0]         s1_count,
    output logic                              s1_advance,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [sle_pkg::STATUS_W-1:0]      status,
    output logic [sle_pkg::OUT_POS_W-1:0]     position,
    output logic [sle_pkg::OUT_CNT_W-1:0]     entry_count
);

    logic                           valid_reg;
    logic                           valid_next;
    logic [sle_pkg::STATUS_W-1:0]   status_reg;
    logic [sle_pkg::OUT_POS_W-1:0]  position_reg;
    logic [sle_pkg::OUT_CNT_W-1:0]  count_reg;

    assign s1_advance = s1_valid && (!valid_reg || out_ready);
    assign valid_next = s1_advance || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            status_reg   <= s1_status;
            position_reg <= sle_pkg::fit_pos(sle_pkg::encode_onehot(s1_onehot));
            count_reg    <= sle_pkg::fit_cnt(s1_count);
        end
    end

    assign out_valid   = valid_reg;
    assign status      = status_reg;
    assign position    = position_reg;
    assign entry_count = count_reg;

endmodule

@@ src/sorted_list_engine_core.sv @@
// ---------------------------------------------------------------------------
// Sorted list engine core
// Ascending sorted store of signed values with insert, delete and search.
// ---------------------------------------------------------------------------
// Requests arrive on the input channel (in_valid, in_ready, req_type,
// item_value) and each produces exactly one result on the output channel
// (out_valid, out_ready, status, position, entry_count).
// The store is a row of cells. Every cell compares its entry with the request
// value in the transfer cycle, and on an insert into a store that is not
// full or a delete that hits, each cell at or past the affected position
// takes its neighbor's entry in that same cycle, so the row is updated
// before the next request is compared. The position is encoded from the
// registered match flags in the result stage. out_valid rises once the
// request has passed the first stage register and the result register, and
// one request is taken per cycle while the receiver keeps up.
// When the receiver stalls, the result register and the stage behind it
// fill, then in_ready drops until the output transfer frees a stage.
// Reset empties the store and clears both stages, dropping any request held in them.
// ---------------------------------------------------------------------------
module sorted_list_engine_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [sle_pkg::REQ_W-1:0]           req_type,
    input  logic signed [sle_pkg::DATA_W-1:0]   item_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sle_pkg::STATUS_W-1:0]        status,
    output logic [sle_pkg::OUT_POS_W-1:0]       position,
    output logic [sle_pkg::OUT_CNT_W-1:0]       entry_count
);

    localparam int CW = sle_pkg::CNT_W;
    localparam int D  = sle_pkg::DEPTH;

    logic signed [sle_pkg::DATA_W-1:0] cell_val [D];
    logic [D-1:0]                      lt_vec;
    logic [D-1:0]                      eq_vec;
    logic [D-1:0]                      boundary;
    logic [D-1:0]                      left_lt_vec;

    logic                              in_fire;
    logic                              full;
    logic                              hit;
    sle_pkg::cell_cmd_t                cmd;

    logic [CW-1:0]                     fill_count_reg;
    logic [CW-1:0]                     fill_count_next;
    logic                              s1_valid_reg;
    logic                              s1_valid_next;
    logic [sle_pkg::STATUS_W-1:0]      s1_status_reg;
    logic [sle_pkg::STATUS_W-1:0]      s1_status_next;
    logic [D-1:0]                      s1_onehot_reg;
    logic [D-1:0]                      s1_onehot_next;
    logic [CW-1:0]                     s1_count_reg;
    logic                              s1_advance;

    assign in_ready = !s1_valid_reg || s1_advance;
    assign in_fire  = in_valid && in_ready;
    assign full     = (fill_count_reg == CW'(D));

    assign left_lt_vec = {lt_vec[D-2:0], 1'b1};
    assign boundary    = ~lt_vec & left_lt_vec | (~lt_vec & {{(D-1){1'b0}}, 1'b1});
    assign hit         = |(boundary & eq_vec);

    assign cmd.value = item_value;
    assign cmd.ins   = in_fire && (req_type == sle_pkg::REQ_INSERT) && !full;
    assign cmd.del   = in_fire && (req_type == sle_pkg::REQ_DELETE) && hit;

    genvar gi;
    generate
        for (gi = 0; gi < D; gi++)
        begin : g_cell
            sle_cell u_cell
            (
                .clk       (clk),
                .cmd       (cmd),
                .occupied  (fill_count_reg > CW'(gi)),
                .left_lt   (left_lt_vec[gi]),
                .left_val  (cell_val[(gi == 0) ? 0 : gi - 1]),
                .right_val (cell_val[(gi == D - 1) ? gi : gi + 1]),
                .val       (cell_val[gi]),
                .lt        (lt_vec[gi]),
                .eq        (eq_vec[gi])
            );
        end
    endgenerate

    always_comb
    begin
        fill_count_next = fill_count_reg;
        s1_status_next  = sle_pkg::ST_MISS;
        s1_onehot_next  = '0;
        case (req_type)
            sle_pkg::REQ_INSERT:
            begin
                if (full)
                begin
                    s1_status_next = sle_pkg::ST_FULL;
                end
                else
                begin
                    s1_status_next = sle_pkg::ST_OK;
                    s1_onehot_next = boundary;
                end
            end
            sle_pkg::REQ_DELETE, sle_pkg::REQ_SEARCH:
            begin
                if (hit)
                begin
                    s1_status_next = sle_pkg::ST_OK;
                    s1_onehot_next = boundary;
                end
            end
            default:
            begin
                s1_status_next = sle_pkg::ST_MISS;
            end
        endcase
        if (cmd.ins)
        begin
            fill_count_next = fill_count_reg + CW'(1);
        end
        else if (cmd.del)
        begin
            fill_count_next = fill_count_reg - CW'(1);
        end
    end

    assign s1_valid_next = in_fire || (s1_valid_reg && !s1_advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
            s1_valid_reg   <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_status_reg <= s1_status_next;
            s1_onehot_reg <= s1_onehot_next;
            s1_count_reg  <= fill_count_next;
        end
    end

    sle_out_stage u_out
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s1_valid    (s1_valid_reg),
        .s1_status   (s1_status_reg),
        .s1_onehot   (s1_onehot_reg),
        .s1_count    (s1_count_reg),
        .s1_advance  (s1_advance),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .position    (position),
        .entry_count (entry_count)
    );

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= CW'(D))
        else $error("fill count exceeds the store depth");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && req_type == sle_pkg::REQ_INSERT && full
        |=> s1_status_reg == sle_pkg::ST_FULL && fill_count_reg == CW'(D))
        else $error("insert into a full store was not dropped");

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> $onehot0(s1_onehot_reg))
        else $error("more than one position flagged");

    a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != sle_pkg::ST_OK |-> position == '0)
        else $error("nonzero position with a failing status");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !in_fire && !s1_advance |=> $stable(fill_count_reg))
        else $error("fill count changed without a transfer");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Sorted list engine testbench
// Drives insert, delete, search and unused requests with random sender gaps and
// receiver stalls, and checks every result against a sorted-queue predictor or a directed expected result.
// ---------------------------------------------------------------------------
module testbench;

    localparam logic [sle_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam logic signed [sle_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [sle_pkg::DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam int RANDOM_ITEMS = 650;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [sle_pkg::STATUS_W-1:0]  status;
        logic [sle_pkg::OUT_POS_W-1:0] position;
        logic [sle_pkg::OUT_CNT_W-1:0] entry_count;
    } result_t;

    typedef struct packed {
        logic [sle_pkg::REQ_W-1:0]         req;
        logic signed [sle_pkg::DATA_W-1:0] value;
        logic                              has_exp;
        result_t                           exp;
    } stim_row_t;

    typedef enum logic [1:0] {PH_FILL, PH_DRAIN, PH_MIX} phase_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                in_ready;
    logic [sle_pkg::REQ_W-1:0]           req_type = sle_pkg::REQ_SEARCH;
    logic signed [sle_pkg::DATA_W-1:0]   item_value = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic [sle_pkg::STATUS_W-1:0]        status;
    logic [sle_pkg::OUT_POS_W-1:0]       position;
    logic [sle_pkg::OUT_CNT_W-1:0]       entry_count;

    logic signed [sle_pkg::DATA_W-1:0]   sorted_values[$];
    result_t                             pending_results[$];
    stim_row_t                           directed_rows[$];

    int error_count = 0;
    int burst_left = 0;
    int ready_mode = 0;
    int ready_mode_left = 0;
    int ready_tick = 0;
    int insert_reqs = 0;
    int delete_reqs = 0;
    int search_reqs = 0;
    int unused_reqs = 0;
    int full_drops = 0;
    int miss_results = 0;
    int peak_fill = 0;

    sorted_list_engine_core uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .item_value  (item_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .position    (position),
        .entry_count (entry_count)
    );

    always #4 clk = ~clk;

    function automatic int find_equal_index(input logic signed [sle_pkg::DATA_W-1:0] val);
        int idx;
        idx = -1;
        for (int i = 0; i < sorted_values.size(); i++)
        begin
            if (idx < 0 && sorted_values[i] == val)
            begin
                idx = i;
            end
        end
        return idx;
    endfunction

    function automatic result_t apply_request(input logic [sle_pkg::REQ_W-1:0] req,
                                              input logic signed [sle_pkg::DATA_W-1:0] val);
        result_t r;
        int slot;
        r.status   = sle_pkg::ST_MISS;
        r.position = '0;
        case (req)
            sle_pkg::REQ_INSERT:
            begin
                insert_reqs++;
                if (sorted_values.size() >= sle_pkg::DEPTH)
                begin
                    r.status = sle_pkg::ST_FULL;
                    full_drops++;
                end
                else
                begin
                    slot = sorted_values.size();
                    for (int i = sorted_values.size() - 1; i >= 0; i--)
                    begin
                        if (sorted_values[i] >= val)
                        begin
                            slot = i;
                        end
                    end
                    sorted_values.insert(slot, val);
                    r.status   = sle_pkg::ST_OK;
                    r.position = sle_pkg::OUT_POS_W'(slot);
                end
            end
            sle_pkg::REQ_DELETE:
            begin
                delete_reqs++;
                slot = find_equal_index(val);
                if (slot >= 0)
                begin
                    sorted_values.delete(slot);
                    r.status   = sle_pkg::ST_OK;
                    r.position = sle_pkg::OUT_POS_W'(slot);
                end
            end
            sle_pkg::REQ_SEARCH:
            begin
                search_reqs++;
                slot = find_equal_index(val);
                if (slot >= 0)
                begin
                    r.status   = sle_pkg::ST_OK;
                    r.position = sle_pkg::OUT_POS_W'(slot);
                end
            end
            default:
            begin
                unused_reqs++;
            end
        endcase
        if (r.status == sle_pkg::ST_MISS)
        begin
            miss_results++;
        end
        if (sorted_values.size() > peak_fill)
        begin
            peak_fill = sorted_values.size();
        end
        r.entry_count = sle_pkg::OUT_CNT_W'(sorted_values.size());
        return r;
    endfunction

    function automatic logic signed [sle_pkg::DATA_W-1:0] pick_value();
        logic signed [sle_pkg::DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5, 6:    v = $urandom_range(0, 40) - 20;
            7:          v = VAL_MIN;
            8:          v = VAL_MAX;
            default:
            begin
                if (sorted_values.size() > 0)
                begin
                    v = sorted_values[$urandom_range(0, sorted_values.size() - 1)];
                end
                else
                begin
                    v = $urandom;
                end
            end
        endcase
        return v;
    endfunction

    function automatic logic signed [sle_pkg::DATA_W-1:0] pick_stored();
        logic signed [sle_pkg::DATA_W-1:0] v;
        if (sorted_values.size() > 0)
        begin
            v = sorted_values[$urandom_range(0, sorted_values.size() - 1)];
        end
        else
        begin
            v = pick_value();
        end
        return v;
    endfunction

    task automatic choose_request(input phase_t ph, output logic [sle_pkg::REQ_W-1:0] req,
                                  output logic signed [sle_pkg::DATA_W-1:0] val);
        int roll;
        roll = $urandom_range(0, 99);
        case (ph)
            PH_FILL:
            begin
                req = (roll < 95) ? sle_pkg::REQ_INSERT : sle_pkg::REQ_SEARCH;
                val = pick_value();
            end
            PH_DRAIN:
            begin
                if (roll < 80)
                begin
                    req = sle_pkg::REQ_DELETE;
                    val = pick_stored();
                end
                else if (roll < 85)
                begin
                    req = sle_pkg::REQ_DELETE;
                    val = $urandom;
                end
                else if (roll < 95)
                begin
                    req = sle_pkg::REQ_SEARCH;
                    val = pick_value();
                end
                else
                begin
                    req = REQ_UNUSED;
                    val = $urandom;
                end
            end
            default:
            begin
                if (roll < 40)
                begin
                    req = sle_pkg::REQ_INSERT;
                    val = pick_value();
                end
                else if (roll < 65)
                begin
                    req = sle_pkg::REQ_DELETE;
                    val = pick_stored();
                end
                else if (roll < 80)
                begin
                    req = sle_pkg::REQ_SEARCH;
                    val = pick_stored();
                end
                else if (roll < 95)
                begin
                    req = (roll[0]) ? sle_pkg::REQ_SEARCH : sle_pkg::REQ_DELETE;
                    val = pick_value();
                end
                else
                begin
                    req = REQ_UNUSED;
                    val = pick_value();
                end
            end
        endcase
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic send_request(input logic [sle_pkg::REQ_W-1:0] req,
                                input logic signed [sle_pkg::DATA_W-1:0] val,
                                input logic use_typed, input result_t typed);
        result_t predicted;
        in_valid   <= 1'b1;
        req_type   <= req;
        item_value <= val;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        predicted = apply_request(req, val);
        pending_results.push_back(use_typed ? typed : predicted);
    endtask

    task automatic add_row(input logic [sle_pkg::REQ_W-1:0] req,
                           input logic signed [sle_pkg::DATA_W-1:0] val,
                           input logic has_exp, input logic [sle_pkg::STATUS_W-1:0] st,
                           input int pos, input int cnt);
        stim_row_t row;
        row.req                = req;
        row.value              = val;
        row.has_exp            = has_exp;
        row.exp.status         = st;
        row.exp.position       = sle_pkg::OUT_POS_W'(pos);
        row.exp.entry_count    = sle_pkg::OUT_CNT_W'(cnt);
        directed_rows.push_back(row);
    endtask

    // The receiver switches between free running, random, periodic and
    // mostly stalled behavior at random intervals.
    always @(posedge clk)
    begin
        ready_tick <= ready_tick + 1;
        if (ready_mode_left == 0)
        begin
            ready_mode      <= $urandom_range(0, 3);
            ready_mode_left <= $urandom_range(10, 60);
        end
        else
        begin
            ready_mode_left <= ready_mode_left - 1;
        end
        case (ready_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 1) == 1);
            2:       out_ready <= (ready_tick % 4 == 0);
            default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                begin
                    $display("unexpected result: status %0d position %0d count %0d",
                             status, position, entry_count);
                end
            end
            else if (status != pending_results[0].status
                     || position != pending_results[0].position
                     || entry_count != pending_results[0].entry_count)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                begin
                    $display({"mismatch: expected status %0d position %0d count %0d,",
                              " got %0d %0d %0d"},
                             pending_results[0].status, pending_results[0].position,
                             pending_results[0].entry_count, status, position, entry_count);
                end
                void'(pending_results.pop_front());
            end
            else
            begin
                void'(pending_results.pop_front());
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        logic [sle_pkg::REQ_W-1:0]         req;
        logic signed [sle_pkg::DATA_W-1:0] val;
        phase_t                            ph;
        int                                phase_left;
        int                                sent;

        add_row(sle_pkg::REQ_SEARCH, 0,              1'b1, sle_pkg::ST_MISS, 0, 0);
        add_row(sle_pkg::REQ_DELETE, VAL_MIN,        1'b1, sle_pkg::ST_MISS, 0, 0);
        add_row(REQ_UNUSED,          -1,             1'b1, sle_pkg::ST_MISS, 0, 0);
        add_row(sle_pkg::REQ_INSERT, VAL_MAX,        1'b1, sle_pkg::ST_OK,   0, 1);
        add_row(sle_pkg::REQ_INSERT, VAL_MIN,        1'b1, sle_pkg::ST_OK,   0, 2);
        add_row(sle_pkg::REQ_INSERT, 0,              1'b1, sle_pkg::ST_OK,   1, 3);
        add_row(sle_pkg::REQ_INSERT, VAL_MAX,        1'b1, sle_pkg::ST_OK,   2, 4);
        add_row(sle_pkg::REQ_SEARCH, VAL_MAX,        1'b1, sle_pkg::ST_OK,   2, 4);
        add_row(sle_pkg::REQ_SEARCH, -1,             1'b1, sle_pkg::ST_MISS, 0, 4);
        add_row(sle_pkg::REQ_DELETE, VAL_MIN,        1'b1, sle_pkg::ST_OK,   0, 3);
        add_row(sle_pkg::REQ_INSERT, -5,             1'b1, sle_pkg::ST_OK,   0, 4);
        add_row(REQ_UNUSED,          0,              1'b1, sle_pkg::ST_MISS, 0, 4);
        add_row(sle_pkg::REQ_DELETE, VAL_MAX,        1'b1, sle_pkg::ST_OK,   2, 3);
        add_row(sle_pkg::REQ_DELETE, VAL_MAX,        1'b1, sle_pkg::ST_OK,   2, 2);
        add_row(sle_pkg::REQ_INSERT, 7,              1'b1, sle_pkg::ST_OK,   2, 3);
        add_row(sle_pkg::REQ_INSERT, 0,              1'b1, sle_pkg::ST_OK,   1, 4);
        add_row(sle_pkg::REQ_DELETE, 0,              1'b1, sle_pkg::ST_OK,   1, 3);
        add_row(sle_pkg::REQ_INSERT, 32'sh5555_5555, 1'b0, sle_pkg::ST_OK,   0, 0);
        add_row(sle_pkg::REQ_INSERT, 32'shAAAA_AAAA, 1'b0, sle_pkg::ST_OK,   0, 0);
        add_row(sle_pkg::REQ_SEARCH, 32'sh5555_5555, 1'b0, sle_pkg::ST_OK,   0, 0);
        add_row(sle_pkg::REQ_DELETE, 32'shAAAA_AAAA, 1'b0, sle_pkg::ST_OK,   0, 0);
        add_row(sle_pkg::REQ_SEARCH, 32'shAAAA_AAAA, 1'b0, sle_pkg::ST_OK,   0, 0);
        add_row(sle_pkg::REQ_DELETE, -1,             1'b0, sle_pkg::ST_OK,   0, 0);
        add_row(sle_pkg::REQ_INSERT, -1,             1'b0, sle_pkg::ST_OK,   0, 0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            pace_sender();
            send_request(directed_rows[i].req, directed_rows[i].value,
                         directed_rows[i].has_exp, directed_rows[i].exp);
        end

        // Fill to the top first so that full drops are seen early, then drain
        // and alternate with mixed traffic.
        ph         = PH_FILL;
        phase_left = 90;
        sent       = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (phase_left == 0)
            begin
                case (ph)
                    PH_FILL:
                    begin
                        ph         = PH_DRAIN;
                        phase_left = 80;
                    end
                    PH_DRAIN:
                    begin
                        ph         = PH_MIX;
                        phase_left = 100;
                    end
                    default:
                    begin
                        ph         = PH_FILL;
                        phase_left = 90;
                    end
                endcase
            end
            choose_request(ph, req, val);
            pace_sender();
            send_request(req, val, 1'b0, '0);
            phase_left--;
            sent++;
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        $display("%0d inserts, %0d deletes, %0d searches, %0d unused requests",
                 insert_reqs, delete_reqs, search_reqs, unused_reqs);
        $display("%0d inserts dropped on a full store, %0d misses, peak fill %0d of %0d",
                 full_drops, miss_results, peak_fill, sle_pkg::DEPTH);
        if (error_count == 0 && pending_results.size() == 0)
        begin
            $display("testbench OK");
        end
        else
        begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
